@@ design/infix_to_postfix_converter_top_macros.svh @@
// Assertion helpers shared by the converter RTL.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define I2P_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/i2p_pkg.sv @@
package i2p_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH = 32;

	// stacked operator codes
	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_LPAR = 3'd5
	} op_code_t;

	// shift control for the stack cells
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	// ASCII codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// letters, digits and the decimal point pass through
	function automatic logic is_operand(logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
			(c >= CH_LA && c <= CH_LZ) || c == CH_DOT;
	endfunction

	function automatic logic is_operator(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
			c == CH_CARET;
	endfunction

	function automatic op_code_t op_code(logic [7:0] c);
		op_code_t k;
		case (c)
			CH_PLUS:  k = OP_ADD;
			CH_MINUS: k = OP_SUB;
			CH_STAR:  k = OP_MUL;
			CH_SLASH: k = OP_DIV;
			CH_CARET: k = OP_POW;
			default:  k = OP_LPAR;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] code_char(op_code_t k);
		logic [7:0] c;
		case (k)
			OP_ADD:  c = CH_PLUS;
			OP_SUB:  c = CH_MINUS;
			OP_MUL:  c = CH_STAR;
			OP_DIV:  c = CH_SLASH;
			OP_POW:  c = CH_CARET;
			default: c = CH_LPAR;
		endcase
		return c;
	endfunction

	// precedence; '(' ranks below every operator
	function automatic logic [1:0] prec(op_code_t k);
		logic [1:0] p;
		case (k)
			OP_ADD, OP_SUB: p = 2'd1;
			OP_MUL, OP_DIV: p = 2'd2;
			OP_POW:         p = 2'd3;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

@@ design/i2p_cell.sv @@
// One operator stack entry. Push takes the entry nearer the top,
// pop takes the entry farther from it.
module i2p_cell (
	input  logic                clk,
	input  i2p_pkg::cell_ctl_t  ctl,
	input  i2p_pkg::op_code_t   above,
	input  i2p_pkg::op_code_t   below,
	output i2p_pkg::op_code_t   entry
);

	i2p_pkg::op_code_t entry_q;

	// shift with the neighbors
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= above;
		end else if (ctl.pop) begin
			entry_q <= below;
		end
	end

	assign entry = entry_q;

endmodule

@@ design/infix_to_postfix_converter_top.sv @@
// Channel  Direction  Handshake             Beat payload
// in       input      in_valid / in_stall   in_char, end_of_expr
// res      output     res_valid / res_stall out_char, out_valid, expr_done, syntax_error
//
// One character at a time: each is accepted in idle and then decoded. ')' pops its
// operators one by one, then drops its '(' in a further step when operators sat
// above it; an operator pops the entries that rank at or above it, then pushes.
// The end flush pops every entry and then closes.
// The stack is a row of cells; it shifts by one entry per cycle unless a stall holds it.
// arst_n clears control state; stack contents are undefined until pushed.
// A stalled result holds the output register; the block waits before its next beat.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_expr,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_char,
	output logic       out_valid,
	output logic       expr_done,
	output logic       syntax_error
);

	`include "infix_to_postfix_converter_top_macros.svh"

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_CLOSE  = 5'b00100,
		ST_OPPOP  = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [7:0]         char_q;
	logic               last_q;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [CNT_W-1:0]   open_q, open_d;
	logic               err_q, err_d;
	logic               emitted_q, emitted_d;

	logic               res_valid_q;
	logic [7:0]         out_char_q;
	logic               out_valid_q, expr_done_q, syntax_error_q;

	i2p_pkg::op_code_t  stk [STACK_DEPTH];
	i2p_pkg::cell_ctl_t cell_ctl;
	i2p_pkg::op_code_t  push_code;

	logic               accept, can_emit;
	logic               emit, emit_vld, emit_done, emit_err;
	logic [7:0]         emit_char;

	// stack cell row, entry 0 is the top
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		i2p_pkg::op_code_t above, below;
		if (i == 0) begin : g_top
			assign above = push_code;
		end else begin : g_mid
			assign above = stk[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = stk[i];
		end else begin : g_up
			assign below = stk[i+1];
		end
		i2p_cell u_cell (
			.clk   (clk),
			.ctl   (cell_ctl),
			.above (above),
			.below (below),
			.entry (stk[i])
		);
	end

	// character classes and step checks
	i2p_pkg::op_code_t cur_code, top_code, nxt_code;
	logic is_opnd, is_lp, is_rp, is_op, top_ge, full, ovf, step_err, open_left, final_err;

	always_comb begin
		cur_code  = i2p_pkg::op_code(char_q);
		top_code  = stk[0];
		nxt_code  = stk[1];
		is_opnd   = i2p_pkg::is_operand(char_q);
		is_lp     = char_q == i2p_pkg::CH_LPAR;
		is_rp     = char_q == i2p_pkg::CH_RPAR;
		is_op     = i2p_pkg::is_operator(char_q);
		top_ge    = (cnt_q != '0) && (i2p_pkg::prec(top_code) >= i2p_pkg::prec(cur_code));
		full      = cnt_q == FULL;
		ovf       = (is_lp && full) || (is_op && full && !top_ge);
		step_err  = ovf || (is_rp && open_q == '0);
		open_left = (is_lp && !ovf) || (is_rp ? (open_q > ONE) : (open_q != '0));
		final_err = err_q || step_err || open_left;
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign can_emit = !res_valid_q || !res_stall;

	// sequencer
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		open_d    = open_q;
		err_d     = err_q;
		emitted_d = emitted_q;
		cell_ctl  = '0;
		push_code = cur_code;
		emit      = 1'b0;
		emit_char = i2p_pkg::CH_SPACE;
		emit_vld  = 1'b1;
		emit_done = 1'b0;
		emit_err  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emitted_d = 1'b0;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (last_q && final_err) begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_char = '0;
						emit_vld  = 1'b0;
						emit_done = 1'b1;
						emit_err  = 1'b1;
						cnt_d     = '0;
						open_d    = '0;
						err_d     = 1'b0;
						state_d   = ST_IDLE;
					end
				end else if (err_q) begin
					state_d = ST_IDLE;
				end else if (step_err) begin
					err_d   = 1'b1;
					state_d = ST_IDLE;
				end else if (is_opnd) begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_char = char_q;
						emit_done = last_q && cnt_q == '0;
						emitted_d = 1'b1;
						state_d   = last_q ? ST_FLUSH : ST_IDLE;
					end
				end else if (is_lp) begin
					cell_ctl.push = 1'b1;
					cnt_d   = cnt_q + ONE;
					open_d  = open_q + ONE;
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end else if (is_rp) begin
					if (top_code == i2p_pkg::OP_LPAR) begin
						cell_ctl.pop = 1'b1;
						cnt_d   = cnt_q - ONE;
						open_d  = open_q - ONE;
						state_d = last_q ? ST_FLUSH : ST_IDLE;
					end else begin
						state_d = ST_CLOSE;
					end
				end else if (is_op) begin
					if (can_emit) begin
						emit      = 1'b1;
						emitted_d = 1'b1;
						state_d   = ST_OPPOP;
					end
				end else begin
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_CLOSE: begin
				if (top_code == i2p_pkg::OP_LPAR) begin
					cell_ctl.pop = 1'b1;
					cnt_d   = cnt_q - ONE;
					open_d  = open_q - ONE;
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end else if (can_emit) begin
					cell_ctl.pop = 1'b1;
					cnt_d     = cnt_q - ONE;
					emit      = 1'b1;
					emit_char = i2p_pkg::code_char(top_code);
					emit_done = last_q && cnt_q == TWO && nxt_code == i2p_pkg::OP_LPAR;
					emitted_d = 1'b1;
				end
			end
			ST_OPPOP: begin
				if (top_ge) begin
					if (can_emit) begin
						cell_ctl.pop = 1'b1;
						cnt_d     = cnt_q - ONE;
						emit      = 1'b1;
						emit_char = i2p_pkg::code_char(top_code);
					end
				end else begin
					cell_ctl.push = 1'b1;
					cnt_d   = cnt_q + ONE;
					state_d = last_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (cnt_q != '0) begin
					if (can_emit) begin
						cell_ctl.pop = 1'b1;
						cnt_d     = cnt_q - ONE;
						emit      = 1'b1;
						emit_char = i2p_pkg::code_char(top_code);
						emit_done = cnt_q == ONE;
						emitted_d = 1'b1;
					end
				end else if (!emitted_q) begin
					// empty expression result
					if (can_emit) begin
						emit      = 1'b1;
						emit_char = '0;
						emit_vld  = 1'b0;
						emit_done = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			open_q      <= '0;
			err_q       <= 1'b0;
			emitted_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			open_q    <= open_d;
			err_q     <= err_d;
			emitted_q <= emitted_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// input capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= in_char;
			last_q <= end_of_expr;
		end
		if (emit) begin
			out_char_q     <= emit_char;
			out_valid_q    <= emit_vld;
			expr_done_q    <= emit_done;
			syntax_error_q <= emit_err;
		end
	end

	assign res_valid    = res_valid_q;
	assign out_char     = out_char_q;
	assign out_valid    = out_valid_q;
	assign expr_done    = expr_done_q;
	assign syntax_error = syntax_error_q;

	// checks
	`I2P_ASSERT(a_cnt_range, cnt_q <= FULL, "stack count beyond depth")
	`I2P_ASSERT(a_open_le_cnt, open_q <= cnt_q, "open count exceeds stack count")
	`I2P_ASSERT(a_emit_blocked, !(emit && res_valid_q && res_stall), "beat lost under stall")
	`I2P_ASSERT(a_err_beat, !(res_valid_q && syntax_error_q) || (expr_done_q && !out_valid_q), "bad error beat")
	`I2P_ASSERT_NEXT(a_err_clear, emit && emit_done, !err_q, "error flag survived expression end")

endmodule

@@ tb/sv/infix_to_postfix_converter_top_tb.sv @@
module infix_to_postfix_converter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] char_t;

	typedef struct packed {
		char_t ch;
		logic  vld;
		logic  done;
		logic  err;
	} postfix_beat_t;

	localparam int    DEPTH        = i2p_pkg::STACK_DEPTH;
	localparam int    CYCLE_LIMIT  = 400_000;
	localparam int    DRAIN_CYCLES = 100;
	localparam char_t CH_TAB       = 8'h09;

	logic  clk          = 1'b0;
	logic  arst_n       = 1'b0;
	logic  in_valid     = 1'b0;
	logic  in_stall;
	char_t in_char      = 8'h00;
	logic  end_of_expr  = 1'b0;
	logic  res_valid;
	logic  res_stall    = 1'b0;
	char_t out_char;
	logic  out_valid;
	logic  expr_done;
	logic  syntax_error;

	// operator stack mirror and pending postfix beats
	char_t         op_stack [DEPTH];
	int            op_depth     = 0;
	logic          expr_bad     = 1'b0;
	postfix_beat_t postfix_q[$];
	postfix_beat_t head;

	int send_gap_pct   = 31;
	int recv_stall_pct = 67;
	int mismatch_cnt   = 0;
	int cycle_cnt      = 0;

	infix_to_postfix_converter_top #(
		.STACK_DEPTH(DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_char     (in_char),
		.end_of_expr (end_of_expr),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_char    (out_char),
		.out_valid   (out_valid),
		.expr_done   (expr_done),
		.syntax_error(syntax_error)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// postfix predictor
	// ---------------------------------------------------------------
	function automatic logic is_literal(char_t c);
		return (c >= i2p_pkg::CH_0 && c <= i2p_pkg::CH_9) ||
			(c >= i2p_pkg::CH_UA && c <= i2p_pkg::CH_UZ) ||
			(c >= i2p_pkg::CH_LA && c <= i2p_pkg::CH_LZ) || c == i2p_pkg::CH_DOT;
	endfunction

	// -1 for anything that is not a binary operator, so '(' stops a pop run
	function automatic int op_rank(char_t c);
		if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS)
			return 1;
		if (c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH)
			return 2;
		if (c == i2p_pkg::CH_CARET)
			return 3;
		return -1;
	endfunction

	function automatic logic open_pending();
		for (int i = 0; i < op_depth; i++)
			if (op_stack[i] == i2p_pkg::CH_LPAR)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void push_operator(char_t c);
		if (op_depth >= DEPTH) begin
			expr_bad = 1'b1;
		end else begin
			op_stack[op_depth] = c;
			op_depth++;
		end
	endfunction

	function automatic void predict_postfix(char_t c, logic last);
		char_t emitted[$];
		if (!expr_bad) begin
			if (is_literal(c)) begin
				emitted.push_back(c);
			end else if (c == i2p_pkg::CH_LPAR) begin
				push_operator(c);
			end else if (c == i2p_pkg::CH_RPAR) begin
				if (!open_pending()) begin
					expr_bad = 1'b1;
				end else begin
					while (op_stack[op_depth - 1] != i2p_pkg::CH_LPAR) begin
						op_depth--;
						emitted.push_back(op_stack[op_depth]);
					end
					op_depth--;
				end
			end else if (op_rank(c) > 0) begin
				emitted.push_back(i2p_pkg::CH_SPACE);
				while (op_depth > 0 && op_rank(op_stack[op_depth - 1]) >= op_rank(c)) begin
					op_depth--;
					emitted.push_back(op_stack[op_depth]);
				end
				push_operator(c);
			end
		end
		// end of expression: leftover '(' is an error, else flush
		if (last) begin
			if (!expr_bad && open_pending())
				expr_bad = 1'b1;
			if (!expr_bad) begin
				while (op_depth > 0) begin
					op_depth--;
					emitted.push_back(op_stack[op_depth]);
				end
			end
		end
		if (expr_bad) begin
			if (last)
				postfix_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
		end else begin
			if (last && emitted.size() == 0)
				postfix_q.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
			foreach (emitted[i])
				postfix_q.push_back('{emitted[i], 1'b1,
					last && (i == emitted.size() - 1), 1'b0});
		end
		if (last) begin
			op_depth = 0;
			expr_bad = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		mismatch_cnt++;
		$display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk)
		res_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (postfix_q.size() == 0) begin
				report_mismatch("beat with nothing pending", out_char, 0);
			end else begin
				head = postfix_q.pop_front();
				if (out_char !== head.ch)
					report_mismatch("out_char", out_char, head.ch);
				if (out_valid !== head.vld)
					report_mismatch("out_valid", out_valid, head.vld);
				if (expr_done !== head.done)
					report_mismatch("expr_done", expr_done, head.done);
				if (syntax_error !== head.err)
					report_mismatch("syntax_error", syntax_error, head.err);
			end
		end
	end

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------
	task automatic send_char(char_t c, logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		in_char     <= c;
		end_of_expr <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_postfix(c, last);
	endtask

	task automatic send_string(string s, logic close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && (i == s.len() - 1));
	endtask

	// ---------------------------------------------------------------
	// random expression builders
	// ---------------------------------------------------------------
	function automatic char_t pick_operator();
		case ($urandom_range(4))
			0:       return i2p_pkg::CH_PLUS;
			1:       return i2p_pkg::CH_MINUS;
			2:       return i2p_pkg::CH_STAR;
			3:       return i2p_pkg::CH_SLASH;
			default: return i2p_pkg::CH_CARET;
		endcase
	endfunction

	function automatic char_t pick_literal();
		case ($urandom_range(3))
			0:       return char_t'($urandom_range(i2p_pkg::CH_0, i2p_pkg::CH_9));
			1:       return char_t'($urandom_range(i2p_pkg::CH_UA, i2p_pkg::CH_UZ));
			2:       return char_t'($urandom_range(i2p_pkg::CH_LA, i2p_pkg::CH_LZ));
			default: return i2p_pkg::CH_DOT;
		endcase
	endfunction

	task automatic build_expr(ref char_t q[$], input int nest);
		int n_terms;
		int n_chars;
		n_terms = $urandom_range(1, 4);
		for (int i = 0; i < n_terms; i++) begin
			if (i > 0)
				q.push_back(pick_operator());
			if (nest > 0 && $urandom_range(2) == 0) begin
				q.push_back(i2p_pkg::CH_LPAR);
				build_expr(q, nest - 1);
				q.push_back(i2p_pkg::CH_RPAR);
			end else begin
				n_chars = $urandom_range(1, 3);
				repeat (n_chars)
					q.push_back(pick_literal());
			end
			if ($urandom_range(7) == 0)
				q.push_back($urandom_range(1) ? i2p_pkg::CH_SPACE : CH_TAB);
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// operands, dropped characters, and an end beat that emits no character
	task automatic test_passthrough();
		send_string("Az09.Z\t", 1'b0);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h80, 1'b0);
		send_char(i2p_pkg::CH_SPACE, 1'b1);
	endtask

	// every operator, equal-precedence left association, parens, flush
	task automatic test_precedence();
		send_string("(a^b/c)*d-e+f", 1'b1);
	endtask

	// unmatched ')' (rest ignored) and unmatched '(' at the flush
	task automatic test_paren_errors();
		send_string("a)+b", 1'b1);
		send_string("(a", 1'b1);
	endtask

	// fill the stack to the top, then push one more
	task automatic test_overflow();
		repeat (DEPTH - 1)
			send_char(i2p_pkg::CH_LPAR, 1'b0);
		send_string("a+(", 1'b1);
	endtask

	task automatic test_random(int gap_pct, int stall_pct, int n_items);
		char_t q[$];
		int    sent;
		int    kind;
		int    nest;
		int    idx;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			q = {};
			kind = $urandom_range(99);
			if (kind < 70) begin
				build_expr(q, 3);
			end else if (kind < 76) begin
				// deep nesting, around the stack limit half the time
				nest = $urandom_range(1) ? $urandom_range(DEPTH - 4, DEPTH + 1)
					: $urandom_range(4, 12);
				repeat (nest)
					q.push_back(i2p_pkg::CH_LPAR);
				build_expr(q, 0);
				repeat (nest)
					q.push_back(i2p_pkg::CH_RPAR);
			end else if (kind < 90) begin
				// well-formed expression with one defect
				build_expr(q, 2);
				idx = $urandom_range(q.size() - 1);
				case ($urandom_range(3))
					0: q.insert(idx, i2p_pkg::CH_LPAR);
					1: q.insert(idx, i2p_pkg::CH_RPAR);
					2: q[idx] = char_t'($urandom_range(255));
					default: if (q.size() > 1) q.delete(idx);
				endcase
			end else begin
				repeat ($urandom_range(1, 8))
					q.push_back(char_t'($urandom_range(255)));
			end
			foreach (q[i]) begin
				send_char(q[i], i == q.size() - 1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		test_passthrough();
		test_precedence();
		test_paren_errors();
		test_overflow();
		test_random(31, 67, 55);
		test_random(67, 31, 55);
		test_random(0, 0, 56);
		in_valid <= 1'b0;

		while (postfix_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
